[src/wtosc_pkg.sv]
// shared types, constants and helpers of the wavetable oscillator
package wtosc_pkg;

  // output saturation width and modulo unit sizing
  localparam int SampleBits = 16;
  localparam int NumW       = 19;  // signed phase sum before reduction
  localparam int MagW       = 18;  // magnitude of that sum
  localparam int ModSteps   = MagW;
  localparam int LenW       = 17;
  localparam int MulAW      = 32;
  localparam int MulBW      = 18;
  localparam int MulPW      = MulAW + MulBW;

  // register reset values
  localparam logic [16:0] TableLengthRst = 17'd48000;
  localparam logic [15:0] FreqStepRst    = 16'd440;
  localparam logic [15:0] PhaseOffsetRst = 16'd0;
  localparam logic [14:0] AmplitudeRst   = 15'd3277;

  // register indexes
  typedef enum logic [1:0] {
    REG_TABLE_LENGTH = 2'd0,
    REG_FREQ_STEP    = 2'd1,
    REG_PHASE_OFFSET = 2'd2,
    REG_AMPLITUDE    = 2'd3
  } reg_idx_e;

  // kind of one input beat
  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } item_kind_e;

  // request and response of the remainder unit
  typedef struct packed {
    logic                   valid;
    logic signed [NumW-1:0] num;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] res;
  } mod_rsp_t;

  // product divided by 2^15, rounded toward zero
  function automatic logic signed [NumW-1:0] trunc_q15(input logic signed [MulPW-1:0] p);
    logic signed [MulPW-1:0] t;
    t = p + (p[MulPW-1] ? MulPW'(32767) : MulPW'(0));
    return NumW'(t >>> 15);
  endfunction

endpackage

[src/wtosc_ram.sv]
// generic single-write, single-read RAM with registered read data
module wtosc_ram #(
  parameter int Width = 16,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/wtosc_mul.sv]
// shared signed multiplier with registered product
module wtosc_mul (
  input  logic                                  clk_i,
  input  logic signed [wtosc_pkg::MulAW-1:0]    a_i,
  input  logic signed [wtosc_pkg::MulBW-1:0]    b_i,
  output logic signed [wtosc_pkg::MulPW-1:0]    p_o
);
  import wtosc_pkg::*;

  logic signed [MulPW-1:0] p_q;

  // one product per cycle
  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

[src/wtosc_mod.sv]
// bit-serial true modulo of a signed sum by the table length
module wtosc_mod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wtosc_pkg::mod_req_t            req_i,
  input  logic [wtosc_pkg::LenW-1:0]     divisor_i,
  output wtosc_pkg::mod_rsp_t            rsp_o
);
  import wtosc_pkg::*;

  localparam int CntW = $clog2(ModSteps);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [MagW-1:0] mag_q;
  logic [15:0]     rem_q;
  logic            neg_q;
  logic            done_q;
  logic [15:0]     res_q;

  logic [LenW-1:0] rem_sh;
  logic            ge;
  logic [15:0]     rem_nxt;
  logic [15:0]     res_fix;

  // one restoring step per cycle, then fold negative sums into range
  always_comb begin
    rem_sh  = {rem_q, mag_q[MagW-1]};
    ge      = rem_sh >= divisor_i;
    rem_nxt = 16'(ge ? rem_sh - divisor_i : rem_sh);
    res_fix = (neg_q && rem_nxt != 16'd0) ? 16'(divisor_i - {1'b0, rem_nxt}) : rem_nxt;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.valid) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(ModSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      neg_q <= req_i.num[NumW-1];
      mag_q <= MagW'(req_i.num[NumW-1] ? -req_i.num : req_i.num);
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[MagW-2:0], 1'b0};
      rem_q <= rem_nxt;
      if (cnt_q == CntW'(ModSteps - 1)) begin
        res_q <= res_fix;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  // checks
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> !busy_q)
    else $error("remainder unit restarted while busy");

  a_res_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> {1'b0, rsp_o.res} < divisor_i)
    else $error("remainder not below divisor");

endmodule

[src/wavetable_oscillator_modulated.sv]
// Wavetable oscillator top level: config port, sequencer, output register.
// A table-write beat is accepted while idle and written straight into the wave RAM.
// A sample beat keeps the input stalled until its sample is loaded into the output
// register. The sequencer waits twice on the bit-serial remainder unit (18 steps and
// a done strobe, first for the read index, then for the next phase); besides that it
// issues the two sums, makes four passes through the shared multiplier (one
// of them alongside the RAM read) and loads the output. A finished sample waits in the
// output register while the next beat is accepted; a sample that finds the previous
// one still unaccepted holds at the output load until that one leaves. The wave RAM
// has no reset; entries must be written before they are read. Config writes are
// expected while idle.
module wavetable_oscillator_modulated #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [15:0]        table_index_i,
  input  logic signed [15:0] table_value_i,
  input  logic signed [15:0] phase_mod_i,
  input  logic signed [15:0] freq_mod_i,
  input  logic signed [15:0] amp_mod_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o
);
  import wtosc_pkg::*;

  localparam int LenCap   = (TABLE_DEPTH < 65536) ? TABLE_DEPTH : 65536;
  localparam int MemDepth = LenCap;
  localparam int AddrW    = $clog2(MemDepth);
  localparam logic signed [19:0] SatMax = 20'sd1 <<< (SampleBits - 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MULP  = 10'b0000000010,
    S_SUMP  = 10'b0000000100,
    S_MODP  = 10'b0000001000,
    S_RAMRD = 10'b0000010000,
    S_SUMF  = 10'b0000100000,
    S_MODF  = 10'b0001000000,
    S_MULA  = 10'b0010000000,
    S_MULM  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [16:0] table_length_q;
  logic [15:0] freq_step_q;
  logic [15:0] phase_offset_q;
  logic [14:0] amplitude_q;

  logic [15:0]        acc_q;
  logic [15:0]        idx_q;
  logic signed [15:0] pm_q;
  logic signed [15:0] fm_q;
  logic signed [16:0] am_q;
  logic               out_valid_q;
  logic signed [15:0] sample_q;

  logic [LenW-1:0]          len;
  logic                     cfg_wr;
  logic                     in_acc;
  logic                     ram_we;
  logic [15:0]              ram_rdata;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [MulPW-1:0]  mul_p;
  logic signed [NumW-1:0]   mterm;
  mod_req_t                 mod_req;
  mod_rsp_t                 mod_rsp;
  logic signed [MulPW-1:0]  prod_rnd;
  logic signed [19:0]       smp;
  logic signed [15:0]       smp_sat;
  logic                     out_free;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= TableLengthRst;
      freq_step_q    <= FreqStepRst;
      phase_offset_q <= PhaseOffsetRst;
      amplitude_q    <= AmplitudeRst;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_TABLE_LENGTH: table_length_q <= pwdata[16:0];
        REG_FREQ_STEP:    freq_step_q    <= pwdata[15:0];
        REG_PHASE_OFFSET: phase_offset_q <= pwdata[15:0];
        REG_AMPLITUDE:    amplitude_q    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_TABLE_LENGTH: prdata = 32'(table_length_q);
      REG_FREQ_STEP:    prdata = 32'(freq_step_q);
      REG_PHASE_OFFSET: prdata = 32'(phase_offset_q);
      REG_AMPLITUDE:    prdata = 32'(amplitude_q);
      default:          prdata = '0;
    endcase
  end

  // effective table length: zero reads as one, clipped to the RAM size
  always_comb begin
    if (table_length_q == '0) begin
      len = LenW'(1);
    end else if (32'(table_length_q) > LenCap) begin
      len = LenW'(LenCap);
    end else begin
      len = table_length_q;
    end
  end

  // input handshake and table writes
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ram_we     = in_acc && (kind_i == KIND_WRITE) && (32'(table_index_i) < MemDepth);

  wtosc_ram #(
    .Width(16),
    .Depth(MemDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(table_index_i[AddrW-1:0]),
    .wdata_i(table_value_i),
    .re_i   (state_q == S_RAMRD),
    .raddr_i(idx_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  // multiplier operand select
  always_comb begin
    case (state_q)
      S_MULP: begin
        mul_a = MulAW'(pm_q);
        mul_b = $signed({1'b0, len});
      end
      S_RAMRD: begin
        mul_a = MulAW'(fm_q);
        mul_b = $signed({1'b0, len});
      end
      S_MULA: begin
        mul_a = MulAW'($signed(ram_rdata));
        mul_b = $signed({3'b000, amplitude_q});
      end
      default: begin
        mul_a = mul_p[MulAW-1:0];
        mul_b = MulBW'(am_q);
      end
    endcase
  end

  wtosc_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // phase sums fed to the remainder unit
  assign mterm = trunc_q15(mul_p);

  always_comb begin
    mod_req.valid = (state_q == S_SUMP) || (state_q == S_SUMF);
    if (state_q == S_SUMP) begin
      mod_req.num = $signed({3'b000, acc_q}) + $signed({3'b000, phase_offset_q}) + mterm;
    end else begin
      mod_req.num = $signed({3'b000, acc_q}) + $signed({3'b000, freq_step_q}) + mterm;
    end
  end

  wtosc_mod u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mod_req),
    .divisor_i(len),
    .rsp_o    (mod_rsp)
  );

  // scale by 2^-30 toward zero, then saturate
  always_comb begin
    prod_rnd = mul_p + (mul_p[MulPW-1] ? MulPW'(32'h3FFF_FFFF) : MulPW'(0));
    smp      = 20'(prod_rnd >>> 30);
    if (smp > SatMax - 20'sd1) begin
      smp_sat = 16'(SatMax - 20'sd1);
    end else if (smp < -SatMax) begin
      smp_sat = 16'(-SatMax);
    end else begin
      smp_sat = 16'(smp);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && (kind_i == KIND_SAMPLE)) state_d = S_MULP;
      S_MULP:  state_d = S_SUMP;
      S_SUMP:  state_d = S_MODP;
      S_MODP:  if (mod_rsp.done) state_d = S_RAMRD;
      S_RAMRD: state_d = S_SUMF;
      S_SUMF:  state_d = S_MODF;
      S_MODF:  if (mod_rsp.done) state_d = S_MULA;
      S_MULA:  state_d = S_MULM;
      S_MULM:  state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_MODF && mod_rsp.done) begin
        acc_q <= mod_rsp.res;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc && (kind_i == KIND_SAMPLE)) begin
      pm_q <= phase_mod_i;
      fm_q <= freq_mod_i;
      am_q <= (amp_mod_i == 16'sd0) ? 17'sd32768 : 17'(amp_mod_i);
    end
    if (state_q == S_MODP && mod_rsp.done) begin
      idx_q <= mod_rsp.res;
    end
    if (state_q == S_OUT && out_free) begin
      sample_q <= smp_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  // checks
  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == S_MODP || state_q == S_MODF))
    else $error("remainder done outside a wait state");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RAMRD |-> {1'b0, idx_q} < len)
    else $error("read index not below table length");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> state_q == S_OUT)
    else $error("sample dropped while output stalled");

  a_acc_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == S_MODF && mod_rsp.done) |=> $stable(acc_q))
    else $error("phase changed outside its update");

endmodule
